// ===== rtl/core/mlr_pkg.sv =====
`timescale 1ns / 1ps

package mlr_pkg;

    // Default coordinate width and fixed color width
    localparam int COORD_BITS_DEF = 10;
    localparam int COLOR_BITS     = 32;

    // Color after reset: opaque-less white (R, G, B = 0xFF, A = 0x00)
    localparam logic [COLOR_BITS-1:0] COLOR_RESET = 32'hFFFF_FF00;

    // Command codes carried in func
    localparam logic FUNC_START   = 1'b0;
    localparam logic FUNC_ADVANCE = 1'b1;

    // Classification flags handed from the front to the back with each item
    typedef struct packed {
        logic is_start;
        logic steep;
        logic y_down;
    } cmd_flags_t;

endpackage

// ===== rtl/core/midpoint_line_rasterizer_unit.sv =====
`timescale 1ns / 1ps

// Channel   | Ports                                        | Direction
// ----------+----------------------------------------------+----------
// command   | s_valid s_ready s_func s_start_x/y s_end_x/y | in
// pixel     | m_valid m_ready m_pixel_x/y m_pixel_rgba     | out
//           | m_last                                       |
// color cfg | cfg_valid cfg_ready cfg_data                 | in
//
// One command per clock while the queue is not full; a pixel passes from the queue
// write through the stepper into the output register. The stepper's single
// add-and-compare per pixel sets the one-pixel-per-clock rate while the output is not stalled.
// Reset (aresetn low, synchronous) empties the queue, drops any active line
// and restores the color to 0xFFFFFF00.
// A stalled pixel output holds the stepper; the two-entry queue keeps
// taking commands until it is full.

module midpoint_line_rasterizer_unit #(
    parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_func,
    input  logic [COORD_BITS-1:0]          s_start_x,
    input  logic [COORD_BITS-1:0]          s_start_y,
    input  logic [COORD_BITS-1:0]          s_end_x,
    input  logic [COORD_BITS-1:0]          s_end_y,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [COORD_BITS-1:0]          m_pixel_x,
    output logic [COORD_BITS-1:0]          m_pixel_y,
    output logic [mlr_pkg::COLOR_BITS-1:0] m_pixel_rgba,
    output logic                           m_last,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mlr_pkg::COLOR_BITS-1:0] cfg_data
);

    logic                           q_valid;
    logic                           q_ready;
    mlr_pkg::cmd_flags_t            q_flags;
    logic [COORD_BITS-1:0]          q_x;
    logic [COORD_BITS-1:0]          q_y;
    logic signed [COORD_BITS+2:0]   q_decision;
    logic signed [COORD_BITS+2:0]   q_inc_straight;
    logic signed [COORD_BITS+2:0]   q_inc_diagonal;
    logic [COORD_BITS:0]            q_steps;
    logic [mlr_pkg::COLOR_BITS-1:0] color_reg, color_next;
    logic                           line_busy;

    // Color register
    assign cfg_ready  = 1'b1;
    assign color_next = (cfg_valid && cfg_ready) ? cfg_data : color_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_reg <= mlr_pkg::COLOR_RESET;
        end else begin
            color_reg <= color_next;
        end
    end

    mlr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_start_x      (s_start_x),
        .s_start_y      (s_start_y),
        .s_end_x        (s_end_x),
        .s_end_y        (s_end_y),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_flags        (q_flags),
        .q_x            (q_x),
        .q_y            (q_y),
        .q_decision     (q_decision),
        .q_inc_straight (q_inc_straight),
        .q_inc_diagonal (q_inc_diagonal),
        .q_steps        (q_steps)
    );

    mlr_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_flags        (q_flags),
        .q_x            (q_x),
        .q_y            (q_y),
        .q_decision     (q_decision),
        .q_inc_straight (q_inc_straight),
        .q_inc_diagonal (q_inc_diagonal),
        .q_steps        (q_steps),
        .color          (color_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_x      (m_pixel_x),
        .m_pixel_y      (m_pixel_y),
        .m_pixel_rgba   (m_pixel_rgba),
        .m_last         (m_last),
        .line_busy      (line_busy)
    );

    // A waiting pixel marks last exactly when its line has nothing left
    a_last_matches_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (line_busy == !m_last))
        else $error("last flag disagrees with line state");

    // With no queued command, a drained output stays empty
    a_no_phantom_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        (!q_valid && (!m_valid || m_ready)) |=> !m_valid)
        else $error("pixel emitted without a command");

    // An idle stepper given an advance emits nothing and stays idle
    a_idle_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && q_ready && !q_flags.is_start && !line_busy) |=> (!m_valid && !line_busy))
        else $error("advance while idle changed state");

endmodule

// ===== rtl/core/mlr_front.sv =====
`timescale 1ns / 1ps

module mlr_front #(
    parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // Command input
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_func,
    input  logic [COORD_BITS-1:0]     s_start_x,
    input  logic [COORD_BITS-1:0]     s_start_y,
    input  logic [COORD_BITS-1:0]     s_end_x,
    input  logic [COORD_BITS-1:0]     s_end_y,
    // Classified command queue toward the stepper
    output logic                      q_valid,
    input  logic                      q_ready,
    output mlr_pkg::cmd_flags_t       q_flags,
    output logic [COORD_BITS-1:0]     q_x,
    output logic [COORD_BITS-1:0]     q_y,
    output logic signed [COORD_BITS+2:0] q_decision,
    output logic signed [COORD_BITS+2:0] q_inc_straight,
    output logic signed [COORD_BITS+2:0] q_inc_diagonal,
    output logic [COORD_BITS:0]       q_steps
);

    localparam int DW     = COORD_BITS + 3;
    localparam int SW     = COORD_BITS + 1;
    localparam int QDEPTH = 2;
    localparam int CNTW   = $clog2(QDEPTH + 1);

    // Decode results
    mlr_pkg::cmd_flags_t    dec_flags;
    logic [COORD_BITS-1:0]  dec_x;
    logic [COORD_BITS-1:0]  dec_y;
    logic [COORD_BITS-1:0]  end_xo;
    logic [COORD_BITS-1:0]  end_yo;
    logic [COORD_BITS-1:0]  dx;
    logic [COORD_BITS-1:0]  dy;
    logic [COORD_BITS-1:0]  major;
    logic [COORD_BITS-1:0]  minor;
    logic signed [DW-1:0]   dec_decision;
    logic signed [DW-1:0]   dec_inc_s;
    logic signed [DW-1:0]   dec_inc_d;
    logic [SW-1:0]          dec_steps;

    // Queue storage and pointers
    mlr_pkg::cmd_flags_t    flags_mem [QDEPTH];
    logic [COORD_BITS-1:0]  x_mem     [QDEPTH];
    logic [COORD_BITS-1:0]  y_mem     [QDEPTH];
    logic signed [DW-1:0]   dec_mem   [QDEPTH];
    logic signed [DW-1:0]   incs_mem  [QDEPTH];
    logic signed [DW-1:0]   incd_mem  [QDEPTH];
    logic [SW-1:0]          steps_mem [QDEPTH];

    logic                   wr_ptr_reg, wr_ptr_next;
    logic                   rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]        count_reg,  count_next;
    logic                   push;
    logic                   pop;

    // Order endpoints left to right, pick major axis and y direction
    always_comb begin
        if (s_end_x > s_start_x) begin
            dec_x  = s_start_x;
            dec_y  = s_start_y;
            end_xo = s_end_x;
            end_yo = s_end_y;
        end else begin
            dec_x  = s_end_x;
            dec_y  = s_end_y;
            end_xo = s_start_x;
            end_yo = s_start_y;
        end
        dx                 = end_xo - dec_x;
        dec_flags.y_down   = end_yo < dec_y;
        dy                 = dec_flags.y_down ? (dec_y - end_yo) : (end_yo - dec_y);
        dec_flags.steep    = dy > dx;
        dec_flags.is_start = (s_func == mlr_pkg::FUNC_START);
        major              = dec_flags.steep ? dy : dx;
        minor              = dec_flags.steep ? dx : dy;
        dec_inc_s          = $signed({2'b00, minor, 1'b0});
        dec_decision       = dec_inc_s - $signed({3'b000, major});
        dec_inc_d          = dec_inc_s - $signed({2'b00, major, 1'b0});
        dec_steps          = {1'b0, major};
    end

    // Queue control
    assign s_ready = (count_reg != CNTW'(QDEPTH));
    assign q_valid = (count_reg != '0);
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNTW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue payload, no reset needed
    always_ff @(posedge aclk) begin
        if (push) begin
            flags_mem[wr_ptr_reg] <= dec_flags;
            x_mem[wr_ptr_reg]     <= dec_x;
            y_mem[wr_ptr_reg]     <= dec_y;
            dec_mem[wr_ptr_reg]   <= dec_decision;
            incs_mem[wr_ptr_reg]  <= dec_inc_s;
            incd_mem[wr_ptr_reg]  <= dec_inc_d;
            steps_mem[wr_ptr_reg] <= dec_steps;
        end
    end

    assign q_flags        = flags_mem[rd_ptr_reg];
    assign q_x            = x_mem[rd_ptr_reg];
    assign q_y            = y_mem[rd_ptr_reg];
    assign q_decision     = dec_mem[rd_ptr_reg];
    assign q_inc_straight = incs_mem[rd_ptr_reg];
    assign q_inc_diagonal = incd_mem[rd_ptr_reg];
    assign q_steps        = steps_mem[rd_ptr_reg];

endmodule

// ===== rtl/core/mlr_back.sv =====
`timescale 1ns / 1ps

module mlr_back #(
    parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Classified commands from the queue
    input  logic                          q_valid,
    output logic                          q_ready,
    input  mlr_pkg::cmd_flags_t           q_flags,
    input  logic [COORD_BITS-1:0]         q_x,
    input  logic [COORD_BITS-1:0]         q_y,
    input  logic signed [COORD_BITS+2:0]  q_decision,
    input  logic signed [COORD_BITS+2:0]  q_inc_straight,
    input  logic signed [COORD_BITS+2:0]  q_inc_diagonal,
    input  logic [COORD_BITS:0]           q_steps,
    // Current pixel color
    input  logic [mlr_pkg::COLOR_BITS-1:0] color,
    // Pixel output
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [COORD_BITS-1:0]         m_pixel_x,
    output logic [COORD_BITS-1:0]         m_pixel_y,
    output logic [mlr_pkg::COLOR_BITS-1:0] m_pixel_rgba,
    output logic                          m_last,
    // Line still has pixels to emit
    output logic                          line_busy
);

    localparam int DW = COORD_BITS + 3;
    localparam int SW = COORD_BITS + 1;

    // Line state
    logic [COORD_BITS-1:0]  cur_x_reg,     cur_x_next;
    logic [COORD_BITS-1:0]  cur_y_reg,     cur_y_next;
    logic [SW-1:0]          steps_reg,     steps_next;
    logic signed [DW-1:0]   decision_reg,  decision_next;
    logic signed [DW-1:0]   inc_s_reg,     inc_s_next;
    logic signed [DW-1:0]   inc_d_reg,     inc_d_next;
    logic                   steep_reg,     steep_next;
    logic                   y_down_reg,    y_down_next;
    logic                   busy_reg,      busy_next;

    // Output register
    logic                   m_valid_reg,   m_valid_next;
    logic [COORD_BITS-1:0]  m_x_reg;
    logic [COORD_BITS-1:0]  m_y_reg;
    logic [mlr_pkg::COLOR_BITS-1:0] m_rgba_reg;
    logic                   m_last_reg;

    logic                   take;
    logic                   emit;
    logic                   diag;

    // Output slot free or draining this cycle
    assign take    = !m_valid_reg || m_ready;
    assign q_ready = take;
    assign diag    = (decision_reg > DW'(0));

    always_comb begin
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        steps_next    = steps_reg;
        decision_next = decision_reg;
        inc_s_next    = inc_s_reg;
        inc_d_next    = inc_d_reg;
        steep_next    = steep_reg;
        y_down_next   = y_down_reg;
        busy_next     = busy_reg;
        emit          = 1'b0;
        if (q_valid && take) begin
            if (q_flags.is_start) begin
                // Load a new line and show its first pixel
                cur_x_next    = q_x;
                cur_y_next    = q_y;
                steps_next    = q_steps;
                decision_next = q_decision;
                inc_s_next    = q_inc_straight;
                inc_d_next    = q_inc_diagonal;
                steep_next    = q_flags.steep;
                y_down_next   = q_flags.y_down;
                busy_next     = (q_steps != '0);
                emit          = 1'b1;
            end else if (busy_reg) begin
                // One midpoint step along the major axis
                if (steep_reg || diag) begin
                    cur_y_next = y_down_reg ? (cur_y_reg - COORD_BITS'(1))
                                            : (cur_y_reg + COORD_BITS'(1));
                end
                if (!steep_reg || diag) begin
                    cur_x_next = cur_x_reg + COORD_BITS'(1);
                end
                decision_next = decision_reg + (diag ? inc_d_reg : inc_s_reg);
                steps_next    = steps_reg - SW'(1);
                busy_next     = (steps_reg != SW'(1));
                emit          = 1'b1;
            end
        end
        m_valid_next = take ? emit : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg    <= '0;
            cur_y_reg    <= '0;
            steps_reg    <= '0;
            decision_reg <= '0;
            inc_s_reg    <= '0;
            inc_d_reg    <= '0;
            steep_reg    <= 1'b0;
            y_down_reg   <= 1'b0;
            busy_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            cur_x_reg    <= cur_x_next;
            cur_y_reg    <= cur_y_next;
            steps_reg    <= steps_next;
            decision_reg <= decision_next;
            inc_s_reg    <= inc_s_next;
            inc_d_reg    <= inc_d_next;
            steep_reg    <= steep_next;
            y_down_reg   <= y_down_next;
            busy_reg     <= busy_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Pixel payload
    always_ff @(posedge aclk) begin
        if (emit) begin
            m_x_reg    <= cur_x_next;
            m_y_reg    <= cur_y_next;
            m_rgba_reg <= color;
            m_last_reg <= (steps_next == '0);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_pixel_x    = m_x_reg;
    assign m_pixel_y    = m_y_reg;
    assign m_pixel_rgba = m_rgba_reg;
    assign m_last       = m_last_reg;
    assign line_busy    = busy_reg;

endmodule
